// ===== sv/rwm_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, types and a helper function of the running window mean block.
package rwm_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_WINDOW   = 256;
  localparam int ADDR_BITS    = $clog2(MAX_WINDOW);
  localparam int WIN_BITS     = 9;
  localparam int SUM_BITS     = SAMPLE_BITS + 9;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
  localparam int WINDOW_RESET = 16;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic        [WIN_BITS-1:0]    win_t;
  typedef logic        [ADDR_BITS-1:0]   addr_t;

  // Sequencing strobes from the controller to the window datapath.
  typedef struct packed {
    logic rd_en;   // read the entry that leaves the window
    logic upd_en;  // update sum, counters and write the new sample
  } win_ctrl_t;

  // Zero acts as one, anything above the delay line depth acts as the depth.
  function automatic win_t eff_window(input win_t wl);
    win_t w;
    w = wl;
    if (wl == '0) begin
      w = win_t'(1);
    end else if (wl > win_t'(MAX_WINDOW)) begin
      w = win_t'(MAX_WINDOW);
    end
    return w;
  endfunction

endpackage

// ===== sv/running_window_mean_core.sv =====
`timescale 1ns / 1ps
// Top level of the running window mean: handshake, sequencing and output register.
// Usage:
// The block averages a stream of signed 16-bit samples over a window of the
// last window_length samples (1 to 256; zero acts as one, larger values as 256).
// A word on the input channel carries sample and start_req; start_req opens a new
// sequence, and the window is then treated as full of copies of that sample.
// Each input word gives exactly one output word, average, the window sum divided
// by the window and truncated toward zero, saturated to the 16-bit range.
// The configuration channel writes window_length; cfg_ready is always high, and
// writes are expected only while the block is idle.
// Sequencing: the accept reads the delay line memory, the update state updates the
// running sum and writes the memory, the load state loads the divider, and the
// divider then retires one quotient bit per cycle over the 25-bit sum. out_valid
// rises once the quotient is in the output register, and the next input word is
// taken only after that.
// The output register parts the two sides: a new word is accepted while the last
// average still waits. If the receiver stalls, the finished quotient is held in
// the divider until the output register frees up.
// Reset (rst, synchronous) clears the sum, fill count, pointer and first sample
// and sets window_length to 16. The delay line needs no clearing pass.
module running_window_mean_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          sample,
  input  logic                        start_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          average,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [8:0]                  window_length
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_UPDATE  = 5'b00010,
    S_LOAD    = 5'b00100,
    S_DIVIDE  = 5'b01000,
    S_DELIVER = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  rwm_pkg::win_t      window_cfg;
  rwm_pkg::win_t      win;
  rwm_pkg::sample_t   sample_q;
  logic               start_q;
  rwm_pkg::win_ctrl_t win_ctrl;
  rwm_pkg::sum_t      running_sum;
  logic               div_done;
  rwm_pkg::sample_t   div_quotient;

  logic in_accept;
  logic out_free;
  logic out_load;

  // Configuration must be written only while idle (the block does not enforce it), so
  // the effective window is then stable for the whole life of an item.
  assign cfg_ready = 1'b1;
  assign win       = rwm_pkg::eff_window(window_cfg);

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = ((state == S_DIVIDE && div_done) || state == S_DELIVER) && out_free;

  // The memory read for the leaving sample goes out with the accept; the write of
  // the new sample follows in the next cycle, so the read sees the old entry even at the same address.
  assign win_ctrl.rd_en  = in_accept;
  assign win_ctrl.upd_en = (state == S_UPDATE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: state_next = S_LOAD;
      S_LOAD:   state_next = S_DIVIDE;
      S_DIVIDE: begin
        if (div_done) begin
          state_next = out_free ? S_IDLE : S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      window_cfg <= rwm_pkg::win_t'(rwm_pkg::WINDOW_RESET);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        window_cfg <= window_length;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_q <= sample;
      start_q  <= start_req;
    end
    if (out_load) begin
      average <= div_quotient;
    end
  end

  rwm_window u_window (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (win_ctrl),
    .win         (win),
    .sample      (sample_q),
    .start_req   (start_q),
    .running_sum (running_sum)
  );

  rwm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LOAD),
    .dividend (running_sum),
    .divisor  (win),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // An accepted word keeps the input side closed until its result is placed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("input accepted again while an item is in flight");

  // The divider finishes only while the controller waits for it.
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVIDE))
    else $error("divider finished outside the divide phase");

  // A new result appears only at the end of the divide or deliver phase.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DIVIDE || $past(state) == S_DELIVER))
    else $error("output became valid without a finished division");

endmodule

// ===== sv/rwm_window.sv =====
`timescale 1ns / 1ps
// Window datapath: delay line memory, write pointer, fill count and running sum.
module rwm_window (
  input  logic              clk,
  input  logic              rst,
  input  rwm_pkg::win_ctrl_t ctrl,
  input  rwm_pkg::win_t     win,
  input  rwm_pkg::sample_t  sample,
  input  logic              start_req,
  output rwm_pkg::sum_t     running_sum
);

  localparam int SB = rwm_pkg::SAMPLE_BITS;
  localparam int UB = rwm_pkg::SUM_BITS;

  rwm_pkg::sample_t delay_line [rwm_pkg::MAX_WINDOW];
  rwm_pkg::sample_t rd_data;
  rwm_pkg::addr_t   write_pointer;
  rwm_pkg::addr_t   rd_addr;
  rwm_pkg::sample_t first_value;
  rwm_pkg::win_t    seen_count;

  rwm_pkg::win_t    seen_clip;
  rwm_pkg::win_t    seen_count_next;
  rwm_pkg::sample_t oldest;
  rwm_pkg::sum_t    product;
  rwm_pkg::sum_t    running_sum_next;

  // A window of the full depth maps back onto the write pointer itself.
  assign rd_addr = write_pointer - win[rwm_pkg::ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= delay_line[rd_addr];
    end
    if (ctrl.upd_en) begin
      delay_line[write_pointer] <= sample;
    end
  end

  always_comb begin
    seen_clip = (seen_count > win) ? win : seen_count;
    oldest    = (seen_clip < win) ? first_value : rd_data;
    product   = $signed({{(UB-SB){sample[SB-1]}}, sample})
              * $signed({{(UB-rwm_pkg::WIN_BITS){1'b0}}, win});
    if (start_req) begin
      running_sum_next = product;
      seen_count_next  = rwm_pkg::win_t'(1);
    end else begin
      running_sum_next = running_sum
                       + {{(UB-SB){sample[SB-1]}}, sample}
                       - {{(UB-SB){oldest[SB-1]}}, oldest};
      seen_count_next  = (seen_clip < win) ? seen_clip + rwm_pkg::win_t'(1) : seen_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      first_value   <= '0;
      seen_count    <= '0;
      write_pointer <= '0;
    end else if (ctrl.upd_en) begin
      running_sum   <= running_sum_next;
      seen_count    <= seen_count_next;
      write_pointer <= write_pointer + rwm_pkg::addr_t'(1);
      if (start_req) begin
        first_value <= sample;
      end
    end
  end

endmodule

// ===== sv/rwm_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with signed saturation of the result.
module rwm_divider (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rwm_pkg::sum_t    dividend,
  input  rwm_pkg::win_t    divisor,
  output logic             done,
  output rwm_pkg::sample_t quotient
);

  localparam int UB = rwm_pkg::SUM_BITS;
  localparam int WB = rwm_pkg::WIN_BITS;
  localparam int SB = rwm_pkg::SAMPLE_BITS;
  localparam logic [UB-1:0] SAT_POS = UB'((2 ** (SB - 1)) - 1);
  localparam logic [UB-1:0] SAT_NEG = UB'(2 ** (SB - 1));

  logic                            busy;
  logic                            neg;
  logic [UB-1:0]                   mag;
  logic [WB-1:0]                   rem;
  logic [WB-1:0]                   div_q;
  logic [rwm_pkg::DIV_CNT_BITS-1:0] cnt;

  logic [WB:0]   shifted;
  logic          q_bit;
  logic [WB:0]   trial;
  logic [UB-1:0] mag_neg;

  always_comb begin
    shifted = {rem, mag[UB-1]};
    trial   = shifted - {1'b0, div_q};
    q_bit   = (shifted >= {1'b0, div_q});
    mag_neg = -mag;
    if (!neg) begin
      quotient = (mag > SAT_POS) ? SB'(SAT_POS) : mag[SB-1:0];
    end else begin
      quotient = (mag > SAT_NEG) ? SB'(SAT_NEG) : mag_neg[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= rwm_pkg::DIV_CNT_BITS'(UB - 1);
      end else if (busy) begin
        cnt <= cnt - rwm_pkg::DIV_CNT_BITS'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dividend[UB-1];
      mag   <= dividend[UB-1] ? UB'(-dividend) : UB'(dividend);
      rem   <= '0;
      div_q <= divisor;
    end else if (busy) begin
      mag <= {mag[UB-2:0], q_bit};
      rem <= q_bit ? trial[WB-1:0] : shifted[WB-1:0];
    end
  end

endmodule
